// File: hdl/prfp_pkg.sv
// Package for the presence radar frame parser.
// Frame layout constants and the result type; no dependencies.
`default_nettype none

package prfp_pkg;

  localparam int unsigned FrameBytesDef = 23;
  localparam int unsigned IdxW          = 6;

  localparam logic [31:0]     HeaderWord   = 32'hF4F3F2F1;
  localparam logic [IdxW-1:0] HeaderLen    = 6'd4;
  localparam logic [IdxW-1:0] StateOff     = 6'd8;
  localparam logic [IdxW-1:0] DistLowOff   = 6'd15;
  localparam logic [IdxW-1:0] DistHighOff  = 6'd16;

  typedef struct packed {
    logic [7:0]  target_state;
    logic [15:0] target_distance;
  } prfp_result_t;

endpackage

`default_nettype wire

// File: hdl/prfp_core.sv
// Header hunt, frame byte counter and field capture.
// Depends on prfp_pkg.
`default_nettype none

module prfp_core import prfp_pkg::*; #(
  parameter int unsigned FRAME_BYTES = FrameBytesDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         byte_valid_i,
  input  wire logic [7:0]   byte_i,
  output      logic         res_valid_o,
  output      prfp_result_t res_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(FRAME_BYTES - 1);

  logic [23:0]     win_q, win_d;
  logic            in_frame_q, in_frame_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      held_state_q, held_state_d;
  logic [7:0]      held_lo_q, held_lo_d;
  logic [7:0]      held_hi_q, held_hi_d;
  logic            hdr_hit;
  logic            at_last;

  assign hdr_hit = ({win_q, byte_i} == HeaderWord);
  assign at_last = in_frame_q && (idx_q == LastIdx);

  always_comb begin
    win_d        = win_q;
    in_frame_d   = in_frame_q;
    idx_d        = idx_q;
    held_state_d = held_state_q;
    held_lo_d    = held_lo_q;
    held_hi_d    = held_hi_q;
    res_valid_o  = 1'b0;
    res_o.target_state    = held_state_q;
    res_o.target_distance = {(idx_q == DistHighOff) ? byte_i : held_hi_q, held_lo_q};
    if (byte_valid_i) begin
      if (!in_frame_q) begin
        win_d = {win_q[15:0], byte_i};
        if (hdr_hit) begin
          in_frame_d = 1'b1;
          idx_d      = HeaderLen;
        end
      end else begin
        if (idx_q == StateOff)    held_state_d = byte_i;
        if (idx_q == DistLowOff)  held_lo_d    = byte_i;
        if (idx_q == DistHighOff) held_hi_d    = byte_i;
        if (at_last) begin
          res_valid_o = 1'b1;
          in_frame_d  = 1'b0;
          idx_d       = '0;
          win_d       = '0;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q        <= '0;
      in_frame_q   <= 1'b0;
      idx_q        <= '0;
      held_state_q <= '0;
      held_lo_q    <= '0;
      held_hi_q    <= '0;
    end else begin
      win_q        <= win_d;
      in_frame_q   <= in_frame_d;
      idx_q        <= idx_d;
      held_state_q <= held_state_d;
      held_lo_q    <= held_lo_d;
      held_hi_q    <= held_hi_d;
    end
  end

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_frame_q |-> (idx_q >= HeaderLen) && (idx_q <= LastIdx))
    else $error("frame index out of range");

  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_frame_q |-> (idx_q == '0))
    else $error("index not cleared while hunting");

  a_end_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !in_frame_q && (win_q == '0))
    else $error("window or frame flag not cleared after frame");

  a_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_valid_i && !in_frame_q && hdr_hit) |=> in_frame_q && (idx_q == HeaderLen))
    else $error("header seen but frame not started");

endmodule

`default_nettype wire

// File: hdl/presence_radar_frame_parser_unit.sv
// Presence radar frame parser top level: byte input, result output register.
// A result word is registered and appears in the cycle after the last frame byte is taken.
// Throughput: one byte per cycle; input stalls only while a held result is stalled.
// Reset clears the hunt window, frame counter, captured fields and output valid.
// Depends on prfp_pkg and prfp_core.
`default_nettype none

module presence_radar_frame_parser_unit import prfp_pkg::*; #(
  parameter int unsigned FRAME_BYTES = FrameBytesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [7:0]  target_state_o,
  output      logic [15:0] target_distance_o
);

  logic         out_valid_q;
  prfp_result_t res_q;
  prfp_result_t res;
  logic         res_valid;
  logic         accept;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  prfp_core #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(accept),
    .byte_i      (rx_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign target_state_o    = res_q.target_state;
  assign target_distance_o = res_q.target_distance;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !res_valid)
    else $error("result overwrote a stalled word");

  a_res_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> out_valid_q)
    else $error("result not presented");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q)
    else $error("input stalled with empty output register");

endmodule

`default_nettype wire
